/* rtl/spectral_frame_blur_defines.svh */
// Assertion macros shared by the spectral frame blur RTL.
`ifndef SPECTRAL_FRAME_BLUR_DEFINES_SVH
`define SPECTRAL_FRAME_BLUR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, quiet during reset.
`define SFB_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spectral_frame_blur: check failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define SFB_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spectral_frame_blur: check failed");

`else

`define SFB_ASSERT_IMP(label, ante, cons)
`define SFB_ASSERT_NXT(label, ante, cons)

`endif

`endif

/* rtl/sfb_pkg.sv */
// Types, constants and microcode encodings for the spectral frame blur.
`default_nettype none

package sfb_pkg;

	localparam int MAX_FRAMES = 64;
	localparam int FFT_SIZE   = 512;
	localparam int BINS       = FFT_SIZE / 2 + 1;
	localparam int RING_SIZE  = MAX_FRAMES * BINS;

	localparam int ADDR_W  = $clog2(RING_SIZE);
	localparam int FRAME_W = $clog2(MAX_FRAMES);
	localparam int CNT_W   = FRAME_W + 1;
	localparam int POS_W   = $clog2(BINS);

	localparam int AMP_W     = 24;
	localparam int FREQ_W    = 32;
	localparam int SAT_W     = FREQ_W - 1;
	localparam int FNUM_W    = 32;
	localparam int DELAY_W   = 6;
	localparam int SPACING_W = 24;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 1;

	localparam int ASUM_W    = AMP_W + FRAME_W;
	localparam int FSUM_W    = FREQ_W + FRAME_W;
	localparam int DIV_W     = FSUM_W;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);
	localparam int RAM_W     = AMP_W + FREQ_W;
	localparam int STEP_W    = 4;

	localparam logic [CFG_IDX_W-1:0] REG_DELAY_FRAMES = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_BIN_SPACING  = CFG_IDX_W'(1);

	localparam logic [SPACING_W-1:0] SPACING_RESET = SPACING_W'(24000);

	typedef struct packed {
		logic [AMP_W-1:0]         bin_amp;
		logic signed [FREQ_W-1:0] bin_freq;
		logic [FNUM_W-1:0]        frame_number;
		logic                     last_bin;
	} item_t;

	typedef struct packed {
		logic [AMP_W-1:0]         out_amp;
		logic signed [FREQ_W-1:0] out_freq;
		logic                     out_last;
	} result_t;

	typedef enum logic [STEP_W-1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECIDE,
		ST_BRANCH,
		ST_READ,
		ST_DRAIN,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_OUT_MEAN,
		ST_OUT_PASS,
		ST_FINISH
	} step_t;

	typedef enum logic [2:0] {
		JC_NEVER,
		JC_ALWAYS,
		JC_CLEAR_MORE,
		JC_CLEAR_PEND,
		JC_NOT_ACCEPT,
		JC_DELAY_ZERO,
		JC_READ_MORE,
		JC_DIV_BUSY
	} jcond_t;

	typedef struct packed {
		logic   wait_in;
		logic   wait_out;
		logic   clear_en;
		logic   decide;
		logic   rd_issue;
		logic   div_start;
		logic   out_mean;
		logic   out_pass;
		logic   finish;
		jcond_t jcond;
		step_t  target;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic out_stall;
		logic clear_more;
		logic clear_pend;
		logic accept_now;
		logic delay_zero;
		logic read_more;
		logic div_busy;
	} status_t;

endpackage

`default_nettype wire

/* rtl/sfb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* rtl/sfb_div.sv */
// Two-lane restoring divider for the amplitude and frequency sums, one bit per cycle.
`default_nettype none

module sfb_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [sfb_pkg::FRAME_W-1:0]       divisor,
	input  logic [sfb_pkg::ASUM_W-1:0]        amp_sum,
	input  logic signed [sfb_pkg::FSUM_W-1:0] freq_sum,
	output logic                              busy,
	output logic [sfb_pkg::AMP_W-1:0]         quo_amp,
	output logic signed [sfb_pkg::FREQ_W-1:0] quo_freq
);

	logic [sfb_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [sfb_pkg::FRAME_W-1:0]   dvs_q;
	logic                          neg_q;
	logic [sfb_pkg::DIV_W-1:0]     a_q;
	logic [sfb_pkg::DIV_W-1:0]     f_q;
	logic [sfb_pkg::FRAME_W-1:0]   ra_q;
	logic [sfb_pkg::FRAME_W-1:0]   rf_q;

	logic [sfb_pkg::DIV_W-1:0]   fmag;
	logic [sfb_pkg::FRAME_W:0]   ra_sh;
	logic [sfb_pkg::FRAME_W:0]   rf_sh;
	logic [sfb_pkg::FRAME_W:0]   dvs_ext;
	logic                        a_ge;
	logic                        f_ge;
	logic [sfb_pkg::FRAME_W:0]   ra_d;
	logic [sfb_pkg::FRAME_W:0]   rf_d;
	logic [sfb_pkg::FREQ_W-1:0]  fq;

	// Divide magnitudes; restore the sign of the frequency mean at the end.
	assign fmag = freq_sum[sfb_pkg::FSUM_W-1] ? sfb_pkg::DIV_W'(-freq_sum)
		: sfb_pkg::DIV_W'(freq_sum);

	always_comb begin
		dvs_ext = {1'b0, dvs_q};
		ra_sh   = {ra_q, a_q[sfb_pkg::DIV_W-1]};
		rf_sh   = {rf_q, f_q[sfb_pkg::DIV_W-1]};
		a_ge    = ra_sh >= dvs_ext;
		f_ge    = rf_sh >= dvs_ext;
		ra_d    = a_ge ? ra_sh - dvs_ext : ra_sh;
		rf_d    = f_ge ? rf_sh - dvs_ext : rf_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= sfb_pkg::DIV_CNT_W'(sfb_pkg::DIV_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - sfb_pkg::DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			neg_q <= freq_sum[sfb_pkg::FSUM_W-1];
			a_q   <= sfb_pkg::DIV_W'(amp_sum);
			f_q   <= fmag;
			ra_q  <= '0;
			rf_q  <= '0;
		end else if (cnt_q != '0) begin
			// Shift the quotient bit in where the dividend bit left.
			a_q  <= {a_q[sfb_pkg::DIV_W-2:0], a_ge};
			f_q  <= {f_q[sfb_pkg::DIV_W-2:0], f_ge};
			ra_q <= ra_d[sfb_pkg::FRAME_W-1:0];
			rf_q <= rf_d[sfb_pkg::FRAME_W-1:0];
		end
	end

	assign busy     = cnt_q != '0;
	assign quo_amp  = a_q[sfb_pkg::AMP_W-1:0];
	assign fq       = f_q[sfb_pkg::FREQ_W-1:0];
	assign quo_freq = neg_q ? sfb_pkg::FREQ_W'(-fq) : fq;

endmodule

`default_nettype wire

/* rtl/sfb_seq.sv */
// Microcode sequencer: step counter, control store and conditional jumps.
`default_nettype none

module sfb_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  sfb_pkg::status_t status,
	output sfb_pkg::ctrl_t   ctrl,
	output sfb_pkg::step_t   step
);

	sfb_pkg::step_t step_q;
	sfb_pkg::step_t step_d;
	logic           hold;
	logic           jump;

	function automatic sfb_pkg::ctrl_t rom(input sfb_pkg::step_t s);
		sfb_pkg::ctrl_t w;
		w        = '0;
		w.jcond  = sfb_pkg::JC_NEVER;
		w.target = sfb_pkg::ST_IDLE;
		unique case (s)
			sfb_pkg::ST_CLEAR: begin
				w.clear_en = 1'b1;
				w.jcond    = sfb_pkg::JC_CLEAR_MORE;
				w.target   = sfb_pkg::ST_CLEAR;
			end
			sfb_pkg::ST_IDLE: begin
				w.wait_in = 1'b1;
				w.jcond   = sfb_pkg::JC_CLEAR_PEND;
				w.target  = sfb_pkg::ST_CLEAR;
			end
			sfb_pkg::ST_DECIDE: begin
				w.decide = 1'b1;
				w.jcond  = sfb_pkg::JC_NOT_ACCEPT;
				w.target = sfb_pkg::ST_FINISH;
			end
			sfb_pkg::ST_BRANCH: begin
				w.jcond  = sfb_pkg::JC_DELAY_ZERO;
				w.target = sfb_pkg::ST_OUT_PASS;
			end
			sfb_pkg::ST_READ: begin
				w.rd_issue = 1'b1;
				w.jcond    = sfb_pkg::JC_READ_MORE;
				w.target   = sfb_pkg::ST_READ;
			end
			sfb_pkg::ST_DRAIN: begin
				w.jcond = sfb_pkg::JC_NEVER;
			end
			sfb_pkg::ST_DIV_START: begin
				w.div_start = 1'b1;
			end
			sfb_pkg::ST_DIV_WAIT: begin
				w.jcond  = sfb_pkg::JC_DIV_BUSY;
				w.target = sfb_pkg::ST_DIV_WAIT;
			end
			sfb_pkg::ST_OUT_MEAN: begin
				w.wait_out = 1'b1;
				w.out_mean = 1'b1;
				w.jcond    = sfb_pkg::JC_ALWAYS;
				w.target   = sfb_pkg::ST_FINISH;
			end
			sfb_pkg::ST_OUT_PASS: begin
				w.wait_out = 1'b1;
				w.out_pass = 1'b1;
			end
			sfb_pkg::ST_FINISH: begin
				w.finish = 1'b1;
				w.jcond  = sfb_pkg::JC_ALWAYS;
				w.target = sfb_pkg::ST_IDLE;
			end
			default: begin
				w.jcond  = sfb_pkg::JC_ALWAYS;
				w.target = sfb_pkg::ST_IDLE;
			end
		endcase
		return w;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= sfb_pkg::ST_CLEAR;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		ctrl = rom(step_q);
		hold = (ctrl.wait_in && !status.in_valid && !status.clear_pend)
			|| (ctrl.wait_out && status.out_stall);
		unique case (ctrl.jcond)
			sfb_pkg::JC_NEVER:      jump = 1'b0;
			sfb_pkg::JC_ALWAYS:     jump = 1'b1;
			sfb_pkg::JC_CLEAR_MORE: jump = status.clear_more;
			sfb_pkg::JC_CLEAR_PEND: jump = status.clear_pend;
			sfb_pkg::JC_NOT_ACCEPT: jump = !status.accept_now;
			sfb_pkg::JC_DELAY_ZERO: jump = status.delay_zero;
			sfb_pkg::JC_READ_MORE:  jump = status.read_more;
			sfb_pkg::JC_DIV_BUSY:   jump = status.div_busy;
		endcase
		if (hold) begin
			step_d = step_q;
		end else if (jump) begin
			step_d = ctrl.target;
		end else begin
			step_d = sfb_pkg::step_t'(step_q + sfb_pkg::STEP_W'(1));
		end
	end

	assign step = step_q;

endmodule

`default_nettype wire

/* rtl/spectral_frame_blur.sv */
// Top level of the spectral frame blur: datapath, ring memory and sequencer.
// Bins enter on the item channel (valid/ready), one (amplitude, frequency) pair
// per transaction, with frame_number and last_bin. Each bin of an accepted frame
// is stored in a ring of past frames and one result leaves on the result channel
// (valid/ready): the mean of that bin over the last delay_frames stored frames,
// or the bin itself when the delay is zero. Bins of a stale frame give nothing.
// One bin is handled at a time. An averaged bin makes one ring read per averaged
// frame, then goes through the bit-serial divider before its result is loaded;
// a pass-through bin skips both, and a dropped bin gives no result.
// The result register frees the sequencer once it holds a transaction; while
// the receiver stalls with a result still waiting, the next result step holds.
// Reset (and every bin_spacing write) starts a clearing pass over all
// 16448 ring entries, one per cycle, with item_ready low; register writes
// on the cfg port are taken at any time.
`default_nettype none
`include "spectral_frame_blur_defines.svh"

module spectral_frame_blur (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  sfb_pkg::item_t                    item,
	output logic                              result_valid,
	input  logic                              result_ready,
	output sfb_pkg::result_t                  result,
	input  logic                              cfg_we,
	input  logic [sfb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sfb_pkg::CFG_W-1:0]         cfg_wdata
);

	sfb_pkg::ctrl_t   ctrl;
	sfb_pkg::status_t status;
	sfb_pkg::step_t   step;

	logic [sfb_pkg::DELAY_W-1:0]   delay_q;
	logic [sfb_pkg::SPACING_W-1:0] spacing_q;

	logic                        clr_pend_q;
	logic [sfb_pkg::ADDR_W-1:0]  clr_addr_q;
	logic [sfb_pkg::POS_W-1:0]   clr_bin_q;
	logic [sfb_pkg::SAT_W-1:0]   clr_freq_q;
	logic [sfb_pkg::FREQ_W-1:0]  clr_sum;
	logic [sfb_pkg::SAT_W-1:0]   clr_freq_next;
	logic                        clr_last;
	logic                        clr_bin_last;

	sfb_pkg::item_t              item_q;
	logic [sfb_pkg::POS_W-1:0]   pos_q;
	logic [sfb_pkg::FRAME_W-1:0] wf_q;
	logic [sfb_pkg::FNUM_W-1:0]  last_seen_q;
	logic                        accepted_q;
	logic                        newer;
	logic                        accept_now;
	logic                        end_bin;
	logic                        item_fire;

	logic [sfb_pkg::FRAME_W-1:0] kdel;
	logic [sfb_pkg::ADDR_W-1:0]  item_addr;
	logic [sfb_pkg::ADDR_W-1:0]  rd_addr_q;
	logic [sfb_pkg::ADDR_W-1:0]  rd_next;
	logic [sfb_pkg::FRAME_W-1:0] rd_cnt_q;
	logic                        rd_vld_s1;
	logic [sfb_pkg::AMP_W-1:0]   rd_amp;
	logic signed [sfb_pkg::FREQ_W-1:0] rd_freq;
	logic [sfb_pkg::ASUM_W-1:0]  asum_q;
	logic signed [sfb_pkg::FSUM_W-1:0] fsum_q;

	logic                        ram_we;
	logic [sfb_pkg::ADDR_W-1:0]  ram_waddr;
	logic [sfb_pkg::RAM_W-1:0]   ram_wdata;
	logic [sfb_pkg::RAM_W-1:0]   ram_rdata;

	logic                        div_busy;
	logic [sfb_pkg::AMP_W-1:0]   div_amp;
	logic signed [sfb_pkg::FREQ_W-1:0] div_freq;

	logic                        result_valid_q;
	sfb_pkg::result_t            result_q;
	logic                        out_stall;
	logic                        result_load;

	// Configuration and the ring clearing pass.

	assign clr_last     = clr_addr_q == sfb_pkg::ADDR_W'(sfb_pkg::RING_SIZE - 1);
	assign clr_bin_last = clr_bin_q == sfb_pkg::POS_W'(sfb_pkg::BINS - 1);
	assign clr_sum      = sfb_pkg::FREQ_W'(clr_freq_q) + sfb_pkg::FREQ_W'(spacing_q);
	// Saturate the bin-centre frequency at the largest positive value.
	assign clr_freq_next = clr_sum[sfb_pkg::FREQ_W-1] ? '1 : clr_sum[sfb_pkg::SAT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q    <= '0;
			spacing_q  <= sfb_pkg::SPACING_RESET;
			clr_pend_q <= 1'b1;
			clr_addr_q <= '0;
			clr_bin_q  <= '0;
			clr_freq_q <= '0;
		end else begin
			if (ctrl.clear_en) begin
				clr_addr_q <= clr_last ? '0 : clr_addr_q + sfb_pkg::ADDR_W'(1);
				if (clr_bin_last) begin
					clr_bin_q  <= '0;
					clr_freq_q <= '0;
				end else begin
					clr_bin_q  <= clr_bin_q + sfb_pkg::POS_W'(1);
					clr_freq_q <= clr_freq_next;
				end
				if (clr_last) begin
					clr_pend_q <= 1'b0;
				end
			end
			if (cfg_we) begin
				unique case (cfg_index)
					sfb_pkg::REG_DELAY_FRAMES: begin
						delay_q <= cfg_wdata[sfb_pkg::DELAY_W-1:0];
					end
					sfb_pkg::REG_BIN_SPACING: begin
						// New spacing: restart the pass from the first entry.
						spacing_q  <= cfg_wdata[sfb_pkg::SPACING_W-1:0];
						clr_pend_q <= 1'b1;
						clr_addr_q <= '0;
						clr_bin_q  <= '0;
						clr_freq_q <= '0;
					end
				endcase
			end
		end
	end

	// Item intake and frame bookkeeping.

	assign item_ready = ctrl.wait_in && !clr_pend_q;
	assign item_fire  = item_valid && item_ready;
	assign newer      = item_q.frame_number > last_seen_q;
	assign accept_now = (pos_q == '0) ? newer : accepted_q;
	assign end_bin    = item_q.last_bin || (pos_q == sfb_pkg::POS_W'(sfb_pkg::BINS - 1));

	always_ff @(posedge clk) begin
		if (item_fire) begin
			item_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			wf_q        <= '0;
			last_seen_q <= '0;
			accepted_q  <= 1'b0;
		end else begin
			if (ctrl.decide) begin
				accepted_q <= accept_now;
				if (pos_q == '0 && newer) begin
					last_seen_q <= item_q.frame_number;
				end
			end
			if (ctrl.finish) begin
				if (end_bin) begin
					pos_q <= '0;
					if (accepted_q) begin
						wf_q <= (wf_q == sfb_pkg::FRAME_W'(sfb_pkg::MAX_FRAMES - 1))
							? '0 : wf_q + sfb_pkg::FRAME_W'(1);
					end
				end else begin
					pos_q <= pos_q + sfb_pkg::POS_W'(1);
				end
			end
		end
	end

	// Ring access: write the new bin, then walk back one frame per read.

	assign kdel = (32'(delay_q) >= 32'(sfb_pkg::MAX_FRAMES))
		? sfb_pkg::FRAME_W'(sfb_pkg::MAX_FRAMES - 1) : sfb_pkg::FRAME_W'(delay_q);

	assign item_addr = sfb_pkg::ADDR_W'(wf_q) * sfb_pkg::ADDR_W'(sfb_pkg::BINS)
		+ sfb_pkg::ADDR_W'(pos_q);

	assign rd_next = (rd_addr_q < sfb_pkg::ADDR_W'(sfb_pkg::BINS))
		? rd_addr_q + sfb_pkg::ADDR_W'(sfb_pkg::RING_SIZE - sfb_pkg::BINS)
		: rd_addr_q - sfb_pkg::ADDR_W'(sfb_pkg::BINS);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = item_addr;
		ram_wdata = {item_q.bin_amp, item_q.bin_freq};
		if (ctrl.clear_en) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = {{sfb_pkg::AMP_W{1'b0}}, 1'b0, clr_freq_q};
		end else if (ctrl.decide && accept_now) begin
			ram_we = 1'b1;
		end
	end

	sfb_ram #(
		.WIDTH(sfb_pkg::RAM_W),
		.DEPTH(sfb_pkg::RING_SIZE)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_next),
		.rdata(ram_rdata)
	);

	assign rd_amp  = ram_rdata[sfb_pkg::RAM_W-1:sfb_pkg::FREQ_W];
	assign rd_freq = ram_rdata[sfb_pkg::FREQ_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q <= '0;
			rd_cnt_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= ctrl.rd_issue;
			if (ctrl.decide) begin
				rd_addr_q <= item_addr;
				rd_cnt_q  <= '0;
			end else if (ctrl.rd_issue) begin
				rd_addr_q <= rd_next;
				rd_cnt_q  <= rd_cnt_q + sfb_pkg::FRAME_W'(1);
			end
		end
	end

	// Accumulate read data in the cycle after each read is issued.
	always_ff @(posedge clk) begin
		if (ctrl.decide) begin
			asum_q <= '0;
			fsum_q <= '0;
		end else if (rd_vld_s1) begin
			asum_q <= asum_q + sfb_pkg::ASUM_W'(rd_amp);
			fsum_q <= fsum_q + sfb_pkg::FSUM_W'(rd_freq);
		end
	end

	sfb_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ctrl.div_start),
		.divisor (kdel),
		.amp_sum (asum_q),
		.freq_sum(fsum_q),
		.busy    (div_busy),
		.quo_amp (div_amp),
		.quo_freq(div_freq)
	);

	// Result register.

	assign out_stall   = result_valid_q && !result_ready;
	assign result_load = (ctrl.out_mean || ctrl.out_pass) && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (result_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			result_q.out_amp  <= ctrl.out_pass ? item_q.bin_amp : div_amp;
			result_q.out_freq <= ctrl.out_pass ? item_q.bin_freq : div_freq;
			result_q.out_last <= end_bin;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Sequencer.

	always_comb begin
		status.in_valid   = item_valid;
		status.out_stall  = out_stall;
		status.clear_more = !clr_last;
		status.clear_pend = clr_pend_q;
		status.accept_now = accept_now;
		status.delay_zero = kdel == '0;
		status.read_more  = (sfb_pkg::CNT_W'(rd_cnt_q) + sfb_pkg::CNT_W'(1))
			< sfb_pkg::CNT_W'(kdel);
		status.div_busy   = div_busy;
	end

	sfb_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.status(status),
		.ctrl  (ctrl),
		.step  (step)
	);

	`SFB_ASSERT_NXT(a_accept_to_decide, item_valid && item_ready, step == sfb_pkg::ST_DECIDE)
	`SFB_ASSERT_IMP(a_div_start_idle, ctrl.div_start, !div_busy)
	`SFB_ASSERT_IMP(a_sums_drained, ctrl.div_start, !rd_vld_s1 && !ctrl.rd_issue)

endmodule

`default_nettype wire

/* verif/spectral_frame_blur_checker.sv */
// Channel monitor and bin-averaging predictor for the spectral frame blur.
`timescale 1ns / 1ps

module spectral_frame_blur_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	input  logic                          item_ready,
	input  sfb_pkg::item_t                item,
	input  logic                          result_valid,
	input  logic                          result_ready,
	input  sfb_pkg::result_t              result,
	input  logic                          cfg_we,
	input  logic [sfb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sfb_pkg::CFG_W-1:0]     cfg_wdata,
	output int                            mismatches,
	output int                            in_flight,
	output int                            bins_checked
);

	logic [sfb_pkg::AMP_W-1:0]         amp_hist [sfb_pkg::RING_SIZE];
	logic signed [sfb_pkg::FREQ_W-1:0] freq_hist [sfb_pkg::RING_SIZE];

	logic [sfb_pkg::DELAY_W-1:0]   delay_q;
	logic [sfb_pkg::SPACING_W-1:0] spacing_q;
	logic [sfb_pkg::FRAME_W-1:0]   wr_frame;
	logic [sfb_pkg::POS_W-1:0]     bin_pos;
	logic [sfb_pkg::FNUM_W-1:0]    seen_frame;
	logic                          frame_ok;

	sfb_pkg::result_t blurred_bins [$];
	int               err_n;
	int               chk_n;

	// Bin k of every stored frame: zero amplitude, centre frequency k * spacing, saturated.
	task automatic refill_history();
		longint unsigned                   step_hz;
		logic signed [sfb_pkg::FREQ_W-1:0] centre;
		for (int k = 0; k < sfb_pkg::BINS; k++) begin
			step_hz = k;
			step_hz = step_hz * spacing_q;
			centre = (step_hz > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : sfb_pkg::FREQ_W'(step_hz);
			for (int f = 0; f < sfb_pkg::MAX_FRAMES; f++) begin
				amp_hist[f * sfb_pkg::BINS + k]  = '0;
				freq_hist[f * sfb_pkg::BINS + k] = centre;
			end
		end
	endtask

	task automatic blur_bin(input sfb_pkg::item_t b);
		logic             end_bin;
		int               idx;
		int               span;
		int               slot;
		longint unsigned  amp_acc;
		longint           freq_acc;
		sfb_pkg::result_t r;
		if (bin_pos >= sfb_pkg::POS_W'(sfb_pkg::BINS))
			bin_pos = '0;
		// Acceptance is settled on the first bin and holds for the whole frame.
		if (bin_pos == '0) begin
			frame_ok = b.frame_number > seen_frame;
			if (frame_ok)
				seen_frame = b.frame_number;
		end
		end_bin = b.last_bin || (bin_pos == sfb_pkg::POS_W'(sfb_pkg::BINS - 1));
		if (frame_ok) begin
			idx = int'(wr_frame) * sfb_pkg::BINS + int'(bin_pos);
			amp_hist[idx]  = b.bin_amp;
			freq_hist[idx] = b.bin_freq;
			r.out_amp  = b.bin_amp;
			r.out_freq = b.bin_freq;
			r.out_last = end_bin;
			span = int'(delay_q);
			if (span >= sfb_pkg::MAX_FRAMES)
				span = sfb_pkg::MAX_FRAMES - 1;
			if (span != 0) begin
				amp_acc  = 0;
				freq_acc = 0;
				for (int d = 1; d <= span; d++) begin
					slot = (int'(wr_frame) + sfb_pkg::MAX_FRAMES - d) % sfb_pkg::MAX_FRAMES;
					amp_acc  += amp_hist[slot * sfb_pkg::BINS + int'(bin_pos)];
					freq_acc += freq_hist[slot * sfb_pkg::BINS + int'(bin_pos)];
				end
				r.out_amp  = sfb_pkg::AMP_W'(amp_acc / span);
				r.out_freq = sfb_pkg::FREQ_W'(freq_acc / span);
			end
			blurred_bins.push_back(r);
		end
		if (end_bin) begin
			if (frame_ok)
				wr_frame = wr_frame + 1'b1;
			bin_pos = '0;
		end else begin
			bin_pos = bin_pos + 1'b1;
		end
	endtask

	task automatic check_result(input sfb_pkg::result_t got);
		sfb_pkg::result_t want;
		if (blurred_bins.size() == 0) begin
			$error("result with no bin pending: out_amp %h out_freq %0d out_last %b",
				got.out_amp, got.out_freq, got.out_last);
			err_n++;
		end else begin
			want = blurred_bins.pop_front();
			chk_n++;
			if (got.out_amp !== want.out_amp) begin
				$error("out_amp: expected %h, actual %h", want.out_amp, got.out_amp);
				err_n++;
			end
			if (got.out_freq !== want.out_freq) begin
				$error("out_freq: expected %0d, actual %0d", want.out_freq, got.out_freq);
				err_n++;
			end
			if (got.out_last !== want.out_last) begin
				$error("out_last: expected %b, actual %b", want.out_last, got.out_last);
				err_n++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q    = '0;
			spacing_q  = sfb_pkg::SPACING_RESET;
			wr_frame   = '0;
			bin_pos    = '0;
			seen_frame = '0;
			frame_ok   = 1'b0;
			err_n      = 0;
			chk_n      = 0;
			blurred_bins.delete();
			refill_history();
			mismatches   <= 0;
			in_flight    <= 0;
			bins_checked <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == sfb_pkg::REG_DELAY_FRAMES) begin
					delay_q = cfg_wdata[sfb_pkg::DELAY_W-1:0];
				end else if (cfg_index == sfb_pkg::REG_BIN_SPACING) begin
					spacing_q = cfg_wdata[sfb_pkg::SPACING_W-1:0];
					refill_history();
				end
			end
			// Take the result before the new bin: it always belongs to an older transaction.
			if (result_valid && result_ready)
				check_result(result);
			if (item_valid && item_ready)
				blur_bin(item);
			mismatches   <= err_n;
			in_flight    <= blurred_bins.size();
			bins_checked <= chk_n;
		end
	end

endmodule

/* verif/spectral_frame_blur_tb.sv */
// Stimulus, reset, pacing and verdict for the spectral frame blur regression.
`timescale 1ns / 1ps

module spectral_frame_blur_tb;

	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int SETTLE      = 150;
	localparam int PHASE_BINS  = 190;
	localparam int HOLD_CYCLES = 3000;

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          item_valid   = 1'b0;
	logic                          item_ready;
	sfb_pkg::item_t                item         = '0;
	logic                          result_valid;
	logic                          result_ready = 1'b0;
	sfb_pkg::result_t              result;
	logic                          cfg_we       = 1'b0;
	logic [sfb_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
	logic [sfb_pkg::CFG_W-1:0]     cfg_wdata    = '0;

	int mismatches;
	int in_flight;
	int bins_checked;

	int   cycle_count = 0;
	int   send_idle   = 17;
	int   recv_idle   = 70;
	int   bins_sent   = 0;
	int   fresh_bins  = 0;
	logic long_hold   = 1'b0;
	logic hold_taken  = 1'b0;
	int   hold_left   = 0;

	spectral_frame_blur DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	spectral_frame_blur_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.mismatches   (mismatches),
		.in_flight    (in_flight),
		.bins_checked (bins_checked)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off so the block backs up.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			result_ready <= 1'b0;
			hold_left    <= hold_left - 1;
		end else if (long_hold && !hold_taken) begin
			result_ready <= 1'b0;
			hold_left    <= HOLD_CYCLES;
			hold_taken   <= 1'b1;
		end else begin
			result_ready <= ($urandom_range(99, 0) >= recv_idle);
		end
	end

	function automatic sfb_pkg::item_t make_bin(input logic [sfb_pkg::AMP_W-1:0] a,
			input logic [sfb_pkg::FREQ_W-1:0] f, input logic [sfb_pkg::FNUM_W-1:0] n,
			input logic l);
		sfb_pkg::item_t b;
		b.bin_amp      = a;
		b.bin_freq     = f;
		b.frame_number = n;
		b.last_bin     = l;
		return b;
	endfunction

	function automatic logic [sfb_pkg::AMP_W-1:0] pick_amp();
		case ($urandom_range(7, 0))
			0:       return '0;
			1:       return '1;
			default: return sfb_pkg::AMP_W'($urandom);
		endcase
	endfunction

	function automatic logic [sfb_pkg::FREQ_W-1:0] pick_freq();
		case ($urandom_range(7, 0))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return '0;
			default: return $urandom;
		endcase
	endfunction

	// Hold valid and payload until the transaction is taken.
	task automatic send_bin(input sfb_pkg::item_t b);
		while ($urandom_range(99, 0) < send_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= b;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		bins_sent++;
	endtask

	// Only the first bin's frame number matters; the rest carry noise.
	task automatic send_frame(input logic [sfb_pkg::FNUM_W-1:0] fnum, input int len,
			input logic close);
		for (int i = 0; i < len; i++)
			send_bin(make_bin(pick_amp(), pick_freq(),
				(i == 0) ? fnum : sfb_pkg::FNUM_W'($urandom),
				(i == len - 1) ? close : 1'b0));
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Delay first, then spacing, so no delay write lands in a clearing pass.
	task automatic write_regs(input int dly, input logic new_spacing,
			input logic [sfb_pkg::SPACING_W-1:0] sp);
		cfg_we    <= 1'b1;
		cfg_index <= sfb_pkg::REG_DELAY_FRAMES;
		cfg_wdata <= {18'($urandom), 6'(dly)};
		@(posedge clk);
		if (new_spacing) begin
			cfg_index <= sfb_pkg::REG_BIN_SPACING;
			cfg_wdata <= sfb_pkg::CFG_W'(sp);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [sfb_pkg::FNUM_W-1:0]    fnum_hi;
		logic [sfb_pkg::SPACING_W-1:0] sp;
		logic                          sp_new;
		int                            dly;
		int                            len;
		int                            phase_bins;
		int                            settings_n;

		fnum_hi    = 7;
		settings_n = 1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Frame number zero is never taken after reset.
		send_bin(make_bin('1, 32'h7FFF_FFFF, 32'd0, 1'b1));
		// Pass-through at reset delay, field extremes.
		send_bin(make_bin('0, 32'h8000_0000, 32'd1, 1'b0));
		send_bin(make_bin('1, 32'h7FFF_FFFF, $urandom, 1'b0));
		send_bin(make_bin(sfb_pkg::AMP_W'($urandom), 32'hFFFF_FFFF, $urandom, 1'b0));
		send_bin(make_bin(sfb_pkg::AMP_W'($urandom), '0, $urandom, 1'b1));
		wait_drained();
		write_regs(2, 1'b0, '0);
		settings_n++;
		// Averages over the reset ring and the first frame.
		send_bin(make_bin('1, 32'h7FFF_FFFF, 32'd2, 1'b0));
		send_bin(make_bin('1, 32'h8000_0000, $urandom, 1'b0));
		send_bin(make_bin('0, 32'hFFFF_FFFF, $urandom, 1'b0));
		send_bin(make_bin(sfb_pkg::AMP_W'($urandom), $urandom, $urandom, 1'b1));
		// Equal and older frame numbers: dropped, ring stays put.
		send_bin(make_bin(sfb_pkg::AMP_W'($urandom), $urandom, 32'd2, 1'b0));
		send_bin(make_bin(sfb_pkg::AMP_W'($urandom), $urandom, $urandom, 1'b1));
		send_bin(make_bin(sfb_pkg::AMP_W'($urandom), $urandom, 32'd1, 1'b1));
		send_frame(32'd7, 3, 1'b1);

		for (int ph = 0; ph < 8; ph++) begin
			wait_drained();
			sp_new = 1'b0;
			sp     = '0;
			case (ph)
				0: begin dly = 63; sp_new = 1'b1; sp = '1; end
				1: dly = 0;
				2: dly = 1;
				3: begin dly = $urandom_range(62, 2); sp_new = 1'b1; sp = '0; end
				4: dly = 63;
				5: begin
					dly    = $urandom_range(63, 0);
					sp_new = 1'b1;
					sp     = sfb_pkg::SPACING_W'($urandom);
				end
				6: dly = 2;
				default: dly = $urandom_range(63, 0);
			endcase
			write_regs(dly, sp_new, sp);
			settings_n++;
			if (ph == 1)
				long_hold <= 1'b1;
			if (ph == 4)
				fnum_hi = fnum_hi | 32'h8000_0000;
			phase_bins = 0;
			// Full-length frame: ends on the bin count, with or without the last flag.
			if (ph == 0 || ph == 4) begin
				fnum_hi = fnum_hi + 1;
				send_frame(fnum_hi, sfb_pkg::BINS, ph == 4);
				phase_bins += sfb_pkg::BINS;
			end
			while (phase_bins < PHASE_BINS) begin
				if (fresh_bins + phase_bins < 633) begin
					send_idle = 17;
					recv_idle = 70;
				end else if (fresh_bins + phase_bins < 1266) begin
					send_idle = 70;
					recv_idle = 17;
				end else begin
					send_idle = 0;
					recv_idle = 0;
				end
				if ($urandom_range(99, 0) < 85) begin
					fnum_hi = fnum_hi + $urandom_range(4, 1);
					len = ($urandom_range(99, 0) < 3) ? $urandom_range(sfb_pkg::BINS - 1, 13)
						: $urandom_range(12, 1);
					send_frame(fnum_hi, len, 1'b1);
					phase_bins += len;
				end else begin
					send_frame($urandom_range(fnum_hi, 0), $urandom_range(6, 1), 1'b1);
				end
			end
			fresh_bins += phase_bins;
		end

		// Top frame number, then a repeat of it that must be dropped.
		send_frame(32'hFFFF_FFFF, 1, 1'b1);
		send_frame(32'hFFFF_FFFF, 2, 1'b1);
		wait_drained();

		$display("Sent %0d bins (%0d in fresh frames) across %0d register settings",
			bins_sent, fresh_bins, settings_n);
		$display("Checked %0d blurred bins, %0d mismatches", bins_checked, mismatches);
		if (mismatches == 0 && in_flight == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
